// ===== src/socks_pkg.sv =====
// Shared types and constants for the SOCKS handshake sniffer.
// Used by socks_parser, socks_outq and the top level socks_handshake_sniffer.
`default_nettype none

package socks_pkg;

    // Longest user or domain name that is accepted
    localparam logic [7:0] MAX_NAME_LEN = 8'd255;

    // Protocol byte values
    localparam logic [7:0] VER_SOCKS4       = 8'd4;
    localparam logic [7:0] VER_SOCKS5       = 8'd5;
    localparam logic [7:0] CMD_CONNECT      = 8'd1;
    localparam logic [7:0] ATYP_IPV4        = 8'd1;
    localparam logic [7:0] ATYP_DOMAIN      = 8'd3;
    localparam logic [7:0] S4_GRANTED       = 8'd90;
    localparam logic [7:0] S5_SUCCEEDED     = 8'd0;

    // Reply lengths
    localparam logic [8:0] S4_REPLY_LEN     = 9'd8;
    localparam logic [8:0] S5_IPV4_REPLY_LEN = 9'd12;
    localparam logic [8:0] S5_DOM_REPLY_BASE = 9'd9;

    // Result kinds
    localparam logic [2:0] KIND_DOMAIN   = 3'd0;
    localparam logic [2:0] KIND_REQUEST  = 3'd1;
    localparam logic [2:0] KIND_REPLY    = 3'd2;
    localparam logic [2:0] KIND_COMPLETE = 3'd3;
    localparam logic [2:0] KIND_REJECT   = 3'd4;

    // Stage flag bit positions
    localparam int ST_REQ = 0;
    localparam int ST_REP = 1;
    localparam int ST_CPL = 2;
    localparam int ST_REJ = 3;

    // Request parser phases
    typedef enum logic [3:0] {
        PH_VER,
        PH_S4CMD,
        PH_S4PORT,
        PH_S4ADDR,
        PH_S4USER,
        PH_S4DOM,
        PH_S5NM,
        PH_S5METH,
        PH_S5VER,
        PH_S5CMD,
        PH_S5RSV,
        PH_S5ATYP,
        PH_S5ADDR,
        PH_S5DLEN,
        PH_S5DOM,
        PH_S5PORT
    } t_phase;

    // What one byte caused
    typedef enum logic [1:0] {
        EV_NONE,
        EV_DOM,
        EV_DONE,
        EV_REJ
    } t_event;

    // One queue entry: one or two results sharing one snapshot
    typedef struct packed {
        logic [2:0]  kind;
        logic        second;      // a completion result follows this one
        logic [7:0]  out_byte;
        logic [2:0]  socks_version;
        logic [31:0] dest_ipv4;
        logic [15:0] dest_port;
        logic        has_domain;
        logic [9:0]  request_length;
        logic [8:0]  reply_length;
    } t_result;

endpackage

`default_nettype wire

// ===== src/socks_handshake_sniffer.sv =====
// Top level of the SOCKS handshake sniffer: stream ports, parser and result queue.
// Depends on socks_pkg, socks_parser and socks_outq.
`default_nettype none

// Takes one byte of an observed proxy connection per clock cycle (request or
// reply stream selected per word) and parses the SOCKS4/4A or SOCKS5
// handshake byte by byte. Each result is registered in the result queue
// before it appears on the output stream. A byte that yields two results
// (request or reply accepted, then handshake complete) occupies the output
// as two words; the two-entry result queue lets the input keep flowing at
// one byte per cycle while the output is taken every cycle, and the input
// stalls only when the queue is full. Setting new_conn on a byte clears all
// parser state before that byte is handled.
module socks_handshake_sniffer
    import socks_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // input stream
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    input  wire logic [7:0]  i_s_axis_tdata,   // [7:0] data_byte
    input  wire logic [1:0]  i_s_axis_tuser,   // [0] req_type, [1] new_conn
    // result stream
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    // [7:0] out_byte, [10:8] socks_version, [42:11] dest_ipv4,
    // [58:43] dest_port, [59] has_domain, [69:60] request_length,
    // [78:70] reply_length, [79] zero
    output logic [79:0]      o_m_axis_tdata,
    output logic [2:0]       o_m_axis_tuser,   // [2:0] kind
    output logic             o_m_axis_tlast
);

    logic    accept, push, not_full;
    t_result result, head;

    assign o_s_axis_tready = not_full;
    assign accept          = i_s_axis_tvalid && not_full;

    // Byte parser
    socks_parser u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_data_byte (i_s_axis_tdata),
        .i_req_type  (i_s_axis_tuser[0]),
        .i_new_conn  (i_s_axis_tuser[1]),
        .o_push      (push),
        .o_result    (result)
    );

    // Result queue
    socks_outq u_outq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_result   (result),
        .o_not_full (not_full),
        .o_valid    (o_m_axis_tvalid),
        .i_ready    (i_m_axis_tready),
        .o_head     (head),
        .o_kind     (o_m_axis_tuser),
        .o_last     (o_m_axis_tlast)
    );

    // Output word packing
    assign o_m_axis_tdata = {1'b0, head.reply_length, head.request_length,
                             head.has_domain, head.dest_port, head.dest_ipv4,
                             head.socks_version, head.out_byte};

endmodule

`default_nettype wire

// ===== src/socks_parser.sv =====
// Byte-serial SOCKS4/4A/5 request and reply parser state.
// Depends on socks_pkg; feeds result entries into socks_outq.
`default_nettype none

module socks_parser
    import socks_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_accept,
    input  wire logic [7:0] i_data_byte,
    input  wire logic       i_req_type,
    input  wire logic       i_new_conn,
    output logic            o_push,
    output t_result         o_result
);

    logic [2:0]  r_version,   c_version,   n_version;
    t_phase      r_phase,     c_phase,     n_phase;
    logic [9:0]  r_req_pos,   c_req_pos,   n_req_pos;
    logic [8:0]  r_rep_pos,   c_rep_pos,   n_rep_pos;
    logic [7:0]  r_fcount,    c_fcount,    n_fcount;
    logic [8:0]  r_target,    c_target,    n_target;
    logic [31:0] r_addr,      c_addr,      n_addr;
    logic [15:0] r_port,      c_port,      n_port;
    logic        r_domain,    c_domain,    n_domain;
    logic [3:0]  r_flags,     c_flags,     n_flags;
    t_event      ev;
    logic [7:0]  b;
    logic [8:0]  p;

    assign b = i_data_byte;

    // Next state and event for the current byte
    always_comb begin
        // a new connection starts from the reset state
        if (i_new_conn) begin
            c_version = 3'd0;  c_phase = PH_VER;   c_req_pos = 10'd0;
            c_rep_pos = 9'd0;  c_fcount = 8'd0;    c_target = 9'd0;
            c_addr    = 32'd0; c_port = 16'd0;     c_domain = 1'b0;
            c_flags   = 4'd0;
        end else begin
            c_version = r_version; c_phase = r_phase;   c_req_pos = r_req_pos;
            c_rep_pos = r_rep_pos; c_fcount = r_fcount; c_target = r_target;
            c_addr    = r_addr;    c_port = r_port;     c_domain = r_domain;
            c_flags   = r_flags;
        end

        n_version = c_version; n_phase = c_phase;   n_req_pos = c_req_pos;
        n_rep_pos = c_rep_pos; n_fcount = c_fcount; n_target = c_target;
        n_addr    = c_addr;    n_port = c_port;     n_domain = c_domain;
        n_flags   = c_flags;
        ev        = EV_NONE;
        p         = c_rep_pos;

        if (!(c_flags[ST_REJ] || c_flags[ST_CPL])) begin
            if (!i_req_type) begin
                // client request stream
                if (!c_flags[ST_REQ]) begin
                    if (c_req_pos != 10'h3FF) begin
                        n_req_pos = c_req_pos + 10'd1;
                    end
                    case (c_phase)
                        PH_VER: begin
                            if (b == VER_SOCKS4) begin
                                n_version = 3'd4;
                                n_phase   = PH_S4CMD;
                            end else if (b == VER_SOCKS5) begin
                                n_version = 3'd5;
                                n_phase   = PH_S5NM;
                            end else begin
                                ev = EV_REJ;
                            end
                        end
                        PH_S4CMD: begin
                            if (b != CMD_CONNECT) begin
                                ev = EV_REJ;
                            end else begin
                                n_phase  = PH_S4PORT;
                                n_fcount = 8'd0;
                            end
                        end
                        PH_S4PORT: begin
                            n_port = {c_port[7:0], b};
                            if (c_fcount == 8'd1) begin
                                n_phase  = PH_S4ADDR;
                                n_fcount = 8'd0;
                            end else begin
                                n_fcount = c_fcount + 8'd1;
                            end
                        end
                        PH_S4ADDR: begin
                            n_addr = {c_addr[23:0], b};
                            if (c_fcount == 8'd3) begin
                                n_phase  = PH_S4USER;
                                n_fcount = 8'd0;
                            end else begin
                                n_fcount = c_fcount + 8'd1;
                            end
                        end
                        PH_S4USER: begin
                            if (b != 8'd0) begin
                                if (c_fcount >= MAX_NAME_LEN) begin
                                    ev = EV_REJ;
                                end else begin
                                    n_fcount = c_fcount + 8'd1;
                                end
                            end else if (c_addr[31:8] == 24'd0 && c_addr[7:0] != 8'd0) begin
                                // 4A form: a domain name follows the user name
                                n_domain = 1'b1;
                                n_addr   = 32'd0;
                                n_phase  = PH_S4DOM;
                                n_fcount = 8'd0;
                            end else begin
                                ev = EV_DONE;
                            end
                        end
                        PH_S4DOM: begin
                            if (b == 8'd0) begin
                                ev = EV_DONE;
                            end else if (c_fcount >= MAX_NAME_LEN) begin
                                ev = EV_REJ;
                            end else begin
                                n_fcount = c_fcount + 8'd1;
                                ev       = EV_DOM;
                            end
                        end
                        PH_S5NM: begin
                            n_fcount = b;
                            n_phase  = (b == 8'd0) ? PH_S5VER : PH_S5METH;
                        end
                        PH_S5METH: begin
                            n_fcount = c_fcount - 8'd1;
                            if (c_fcount == 8'd1) begin
                                n_phase = PH_S5VER;
                            end
                        end
                        PH_S5VER: begin
                            if (b != VER_SOCKS5) begin
                                ev = EV_REJ;
                            end else begin
                                n_phase = PH_S5CMD;
                            end
                        end
                        PH_S5CMD: begin
                            n_phase = PH_S5RSV;
                        end
                        PH_S5RSV: begin
                            n_phase = PH_S5ATYP;
                        end
                        PH_S5ATYP: begin
                            n_fcount = 8'd0;
                            if (b == ATYP_IPV4) begin
                                n_phase = PH_S5ADDR;
                            end else if (b == ATYP_DOMAIN) begin
                                n_phase = PH_S5DLEN;
                            end else begin
                                ev = EV_REJ;
                            end
                        end
                        PH_S5ADDR: begin
                            n_addr = {c_addr[23:0], b};
                            if (c_fcount == 8'd3) begin
                                n_phase  = PH_S5PORT;
                                n_fcount = 8'd0;
                            end else begin
                                n_fcount = c_fcount + 8'd1;
                            end
                        end
                        PH_S5DLEN: begin
                            if (b > MAX_NAME_LEN) begin
                                ev = EV_REJ;
                            end else begin
                                n_domain = 1'b1;
                                n_addr   = 32'd0;
                                n_fcount = b;
                                n_phase  = (b == 8'd0) ? PH_S5PORT : PH_S5DOM;
                            end
                        end
                        PH_S5DOM: begin
                            n_fcount = c_fcount - 8'd1;
                            if (c_fcount == 8'd1) begin
                                n_phase = PH_S5PORT;
                            end
                            ev = EV_DOM;
                        end
                        PH_S5PORT: begin
                            n_port   = {c_port[7:0], b};
                            n_fcount = c_fcount + 8'd1;
                            if (c_fcount == 8'd1) begin
                                ev = EV_DONE;
                            end
                        end
                        default: begin
                            ev = EV_REJ;
                        end
                    endcase
                end
            end else begin
                // proxy reply stream
                if (!c_flags[ST_REP]) begin
                    if (c_rep_pos != 9'h1FF) begin
                        n_rep_pos = c_rep_pos + 9'd1;
                    end
                    if (c_version == 3'd4) begin
                        if (p == 9'd0 && b != 8'd0) begin
                            ev = EV_REJ;
                        end else if (p == 9'd1 && b != S4_GRANTED) begin
                            ev = EV_REJ;
                        end else begin
                            if (p == 9'd1) begin
                                n_target = S4_REPLY_LEN;
                            end
                            if ({1'b0, p} + 10'd1 == {1'b0, S4_REPLY_LEN}) begin
                                ev = EV_DONE;
                            end
                        end
                    end else if (c_version == 3'd5) begin
                        if ((p inside {9'd0, 9'd2}) && b != VER_SOCKS5) begin
                            ev = EV_REJ;
                        end else if (p == 9'd3 && b != S5_SUCCEEDED) begin
                            ev = EV_REJ;
                        end else if (p == 9'd5 && b != ATYP_IPV4 && b != ATYP_DOMAIN) begin
                            ev = EV_REJ;
                        end else begin
                            if (p == 9'd5) begin
                                n_target = (b == ATYP_IPV4) ? S5_IPV4_REPLY_LEN : 9'd0;
                            end
                            // domain reply: header, length byte, name, port
                            if (p == 9'd6 && c_target == 9'd0) begin
                                n_target = S5_DOM_REPLY_BASE + {1'b0, b};
                            end
                            if (p >= 9'd6 && {1'b0, p} + 10'd1 == {1'b0, n_target}) begin
                                ev = EV_DONE;
                            end
                        end
                    end else begin
                        ev = EV_REJ;
                    end
                end
            end
        end

        // stage flags from the event
        if (ev == EV_REJ) begin
            n_flags[ST_REJ] = 1'b1;
        end else if (ev == EV_DONE) begin
            if (!i_req_type) begin
                n_flags[ST_REQ] = 1'b1;
            end else begin
                n_flags[ST_REP] = 1'b1;
            end
            if (n_flags[ST_REQ] && n_flags[ST_REP]) begin
                n_flags[ST_CPL] = 1'b1;
            end
        end
    end

    // Result entry built from the updated state
    always_comb begin
        o_push                  = i_accept && (ev != EV_NONE);
        o_result.second         = (ev == EV_DONE) && n_flags[ST_CPL];
        o_result.out_byte       = (ev == EV_DOM) ? b : 8'd0;
        o_result.socks_version  = n_version;
        o_result.dest_ipv4      = n_addr;
        o_result.dest_port      = n_port;
        o_result.has_domain     = n_domain;
        o_result.request_length = n_req_pos;
        o_result.reply_length   = n_rep_pos;
        case (ev)
            EV_DOM:  o_result.kind = KIND_DOMAIN;
            EV_REJ:  o_result.kind = KIND_REJECT;
            EV_DONE: o_result.kind = i_req_type ? KIND_REPLY : KIND_REQUEST;
            default: o_result.kind = KIND_DOMAIN;
        endcase
    end

    // Parser state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_version <= 3'd0;
            r_phase   <= PH_VER;
            r_req_pos <= 10'd0;
            r_rep_pos <= 9'd0;
            r_fcount  <= 8'd0;
            r_target  <= 9'd0;
            r_addr    <= 32'd0;
            r_port    <= 16'd0;
            r_domain  <= 1'b0;
            r_flags   <= 4'd0;
        end else if (i_accept) begin
            r_version <= n_version;
            r_phase   <= n_phase;
            r_req_pos <= n_req_pos;
            r_rep_pos <= n_rep_pos;
            r_fcount  <= n_fcount;
            r_target  <= n_target;
            r_addr    <= n_addr;
            r_port    <= n_port;
            r_domain  <= n_domain;
            r_flags   <= n_flags;
        end
    end

endmodule

`default_nettype wire

// ===== src/socks_outq.sv =====
// Two-entry result queue; an entry may carry a trailing completion word.
// Depends on socks_pkg; sits between socks_parser and the output stream.
`default_nettype none

module socks_outq
    import socks_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_push,
    input  wire t_result i_result,
    output logic         o_not_full,
    output logic         o_valid,
    input  wire logic    i_ready,
    output t_result      o_head,
    output logic [2:0]   o_kind,
    output logic         o_last
);

    t_result    r_slot0, r_slot1;
    logic       r_wr_ptr, r_rd_ptr, r_half;
    logic [1:0] r_count;
    logic       take, pop;

    assign o_not_full = (r_count != 2'd2);
    assign o_valid    = (r_count != 2'd0);
    assign o_head     = r_rd_ptr ? r_slot1 : r_slot0;
    // second word of a double entry is the completion report
    assign o_kind     = r_half ? KIND_COMPLETE : o_head.kind;
    assign o_last     = r_half || !o_head.second;
    assign take       = o_valid && i_ready;
    assign pop        = take && o_last;

    // Entry storage
    always_ff @(posedge i_clk) begin
        if (i_push && !r_wr_ptr) begin
            r_slot0 <= i_result;
        end
        if (i_push && r_wr_ptr) begin
            r_slot1 <= i_result;
        end
    end

    // Pointers, fill count and half marker
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
            r_half   <= 1'b0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (pop) begin
                r_rd_ptr <= ~r_rd_ptr;
                r_half   <= 1'b0;
            end else if (take) begin
                r_half   <= 1'b1;
            end
            r_count <= r_count + {1'b0, i_push} - {1'b0, pop};
        end
    end

endmodule

`default_nettype wire

// ===== dv/tb_socks_pkg.sv =====
// Testbench package for the SOCKS handshake sniffer: result record and the handshake tracker
// that predicts and checks results. Depends on socks_pkg.
`timescale 1ns / 100ps

package tb_socks_pkg;
    import socks_pkg::*;

    // One expected result word
    typedef struct {
        logic [2:0]  kind;
        logic [7:0]  out_byte;
        logic [2:0]  version;
        logic [31:0] ipv4;
        logic [15:0] port;
        logic        has_domain;
        logic [9:0]  req_len;
        logic [8:0]  rep_len;
        logic        last;
    } t_socks_result;

    class handshake_tracker;
        t_socks_result pending_results[$];
        int            errors;

        // parser state of the observed connection
        logic [2:0]  version;
        t_phase      phase;
        logic [9:0]  req_pos;
        logic [8:0]  rep_pos;
        logic [7:0]  fcount;
        logic [8:0]  rep_target;
        logic [31:0] addr;
        logic [15:0] port;
        logic        dom;
        logic [3:0]  stage;

        function new();
            errors = 0;
            restart();
        endfunction

        function void restart();
            version    = 3'd0;
            phase      = PH_VER;
            req_pos    = 10'd0;
            rep_pos    = 9'd0;
            fcount     = 8'd0;
            rep_target = 9'd0;
            addr       = 32'd0;
            port       = 16'd0;
            dom        = 1'b0;
            stage      = 4'd0;
        endfunction

        function int pending();
            return pending_results.size();
        endfunction

        // queue a result carrying the current register snapshot
        function void post(logic [2:0] kind, logic [7:0] b, bit is_last);
            t_socks_result r;
            r.kind       = kind;
            r.out_byte   = b;
            r.version    = version;
            r.ipv4       = addr;
            r.port       = port;
            r.has_domain = dom;
            r.req_len    = req_pos;
            r.rep_len    = rep_pos;
            r.last       = is_last;
            pending_results.push_back(r);
        endfunction

        // client request parser, one byte
        function t_event parse_request_byte(logic [7:0] b);
            case (phase)
                PH_VER: begin
                    if (b == VER_SOCKS4) begin
                        version = 3'd4;
                        phase   = PH_S4CMD;
                        return EV_NONE;
                    end
                    if (b == VER_SOCKS5) begin
                        version = 3'd5;
                        phase   = PH_S5NM;
                        return EV_NONE;
                    end
                    return EV_REJ;
                end
                PH_S4CMD: begin
                    if (b != CMD_CONNECT) return EV_REJ;
                    phase  = PH_S4PORT;
                    fcount = 8'd0;
                    return EV_NONE;
                end
                PH_S4PORT: begin
                    port   = {port[7:0], b};
                    fcount = fcount + 8'd1;
                    if (fcount == 8'd2) begin
                        phase  = PH_S4ADDR;
                        fcount = 8'd0;
                    end
                    return EV_NONE;
                end
                PH_S4ADDR: begin
                    addr   = {addr[23:0], b};
                    fcount = fcount + 8'd1;
                    if (fcount == 8'd4) begin
                        phase  = PH_S4USER;
                        fcount = 8'd0;
                    end
                    return EV_NONE;
                end
                PH_S4USER: begin
                    if (b != 8'd0) begin
                        if (fcount >= MAX_NAME_LEN) return EV_REJ;
                        fcount = fcount + 8'd1;
                        return EV_NONE;
                    end
                    // 0.0.0.x with x nonzero marks the 4A domain form
                    if (addr[31:8] == 24'd0 && addr[7:0] != 8'd0) begin
                        dom    = 1'b1;
                        addr   = 32'd0;
                        phase  = PH_S4DOM;
                        fcount = 8'd0;
                        return EV_NONE;
                    end
                    return EV_DONE;
                end
                PH_S4DOM: begin
                    if (b == 8'd0) return EV_DONE;
                    if (fcount >= MAX_NAME_LEN) return EV_REJ;
                    fcount = fcount + 8'd1;
                    return EV_DOM;
                end
                PH_S5NM: begin
                    fcount = b;
                    phase  = (b == 8'd0) ? PH_S5VER : PH_S5METH;
                    return EV_NONE;
                end
                PH_S5METH: begin
                    fcount = fcount - 8'd1;
                    if (fcount == 8'd0) phase = PH_S5VER;
                    return EV_NONE;
                end
                PH_S5VER: begin
                    if (b != VER_SOCKS5) return EV_REJ;
                    phase = PH_S5CMD;
                    return EV_NONE;
                end
                PH_S5CMD: begin
                    phase = PH_S5RSV;
                    return EV_NONE;
                end
                PH_S5RSV: begin
                    phase = PH_S5ATYP;
                    return EV_NONE;
                end
                PH_S5ATYP: begin
                    fcount = 8'd0;
                    if (b == ATYP_IPV4) begin
                        phase = PH_S5ADDR;
                        return EV_NONE;
                    end
                    if (b == ATYP_DOMAIN) begin
                        phase = PH_S5DLEN;
                        return EV_NONE;
                    end
                    return EV_REJ;
                end
                PH_S5ADDR: begin
                    addr   = {addr[23:0], b};
                    fcount = fcount + 8'd1;
                    if (fcount == 8'd4) begin
                        phase  = PH_S5PORT;
                        fcount = 8'd0;
                    end
                    return EV_NONE;
                end
                PH_S5DLEN: begin
                    if (b > MAX_NAME_LEN) return EV_REJ;
                    dom    = 1'b1;
                    addr   = 32'd0;
                    fcount = b;
                    phase  = (b == 8'd0) ? PH_S5PORT : PH_S5DOM;
                    return EV_NONE;
                end
                PH_S5DOM: begin
                    fcount = fcount - 8'd1;
                    if (fcount == 8'd0) phase = PH_S5PORT;
                    return EV_DOM;
                end
                default: begin
                    port   = {port[7:0], b};
                    fcount = fcount + 8'd1;
                    if (fcount == 8'd2) return EV_DONE;
                    return EV_NONE;
                end
            endcase
        endfunction

        // proxy reply checker; pos is the reply position before this byte
        function t_event parse_reply_byte(logic [8:0] pos, logic [7:0] b);
            if (version == 3'd4) begin
                if (pos == 9'd0 && b != 8'd0) return EV_REJ;
                if (pos == 9'd1 && b != S4_GRANTED) return EV_REJ;
                if (pos == 9'd1) rep_target = S4_REPLY_LEN;
                return (int'(pos) + 1 == int'(S4_REPLY_LEN)) ? EV_DONE : EV_NONE;
            end
            if (version != 3'd5) return EV_REJ;
            if ((pos == 9'd0 || pos == 9'd2) && b != VER_SOCKS5) return EV_REJ;
            if (pos == 9'd3 && b != S5_SUCCEEDED) return EV_REJ;
            if (pos == 9'd5) begin
                if (b == ATYP_IPV4) rep_target = S5_IPV4_REPLY_LEN;
                else if (b == ATYP_DOMAIN) rep_target = 9'd0;
                else return EV_REJ;
            end
            // domain reply: length byte gives 9+L total
            if (pos == 9'd6 && rep_target == 9'd0) rep_target = S5_DOM_REPLY_BASE + {1'b0, b};
            if (pos >= 9'd6 && int'(pos) + 1 == int'(rep_target)) return EV_DONE;
            return EV_NONE;
        endfunction

        // account for one accepted word; returns 0 when the block ignores it
        function bit note_byte(logic [7:0] b, bit from_proxy, bit new_conn);
            t_event     ev;
            logic [8:0] pos;
            if (new_conn) restart();
            if (stage[ST_REJ] || stage[ST_CPL]) return 1'b0;
            if (!from_proxy) begin
                if (stage[ST_REQ]) return 1'b0;
                if (req_pos != 10'h3FF) req_pos = req_pos + 10'd1;
                ev = parse_request_byte(b);
            end else begin
                if (stage[ST_REP]) return 1'b0;
                pos = rep_pos;
                if (rep_pos != 9'h1FF) rep_pos = rep_pos + 9'd1;
                ev = parse_reply_byte(pos, b);
            end
            case (ev)
                EV_DOM: post(KIND_DOMAIN, b, 1'b1);
                EV_REJ: begin
                    stage[ST_REJ] = 1'b1;
                    post(KIND_REJECT, 8'd0, 1'b1);
                end
                EV_DONE: begin
                    if (!from_proxy) stage[ST_REQ] = 1'b1;
                    else stage[ST_REP] = 1'b1;
                    if (stage[ST_REQ] && stage[ST_REP]) begin
                        stage[ST_CPL] = 1'b1;
                        post(from_proxy ? KIND_REPLY : KIND_REQUEST, 8'd0, 1'b0);
                        post(KIND_COMPLETE, 8'd0, 1'b1);
                    end else begin
                        post(from_proxy ? KIND_REPLY : KIND_REQUEST, 8'd0, 1'b1);
                    end
                end
                default: ;
            endcase
            return 1'b1;
        endfunction

        task report(string msg);
            errors++;
            if (errors <= 40) $display("[%0t] MISMATCH: %s", $time, msg);
        endtask

        task compare_field(string name, logic [31:0] got, logic [31:0] want);
            if (got !== want) report($sformatf("%s got %0h expected %0h", name, got, want));
        endtask

        // compare one accepted result word against the oldest expectation
        task check_result(logic [79:0] tdata, logic [2:0] tuser, logic tlast);
            t_socks_result want;
            if (pending_results.size() == 0) begin
                report($sformatf("result kind %0d with nothing expected", tuser));
                return;
            end
            want = pending_results.pop_front();
            compare_field("kind", tuser, want.kind);
            compare_field("out_byte", tdata[7:0], want.out_byte);
            compare_field("socks_version", tdata[10:8], want.version);
            compare_field("dest_ipv4", tdata[42:11], want.ipv4);
            compare_field("dest_port", tdata[58:43], want.port);
            compare_field("has_domain", tdata[59], want.has_domain);
            compare_field("request_length", tdata[69:60], want.req_len);
            compare_field("reply_length", tdata[78:70], want.rep_len);
            compare_field("pad bit", tdata[79], 1'b0);
            compare_field("last", tlast, want.last);
        endtask
    endclass

endpackage

// ===== dv/tb_top.sv =====
// Top-level testbench for socks_handshake_sniffer: clock, reset, byte stream driver,
// result monitor and random handshake traffic. Depends on socks_pkg and tb_socks_pkg.
`timescale 1ns / 100ps

module tb_top;
    import socks_pkg::*;
    import tb_socks_pkg::*;

    localparam int LIMIT       = 500000;
    localparam bit FROM_CLIENT = 1'b0;
    localparam bit FROM_PROXY  = 1'b1;

    logic        i_clk     = 1'b0;
    logic        i_rst_n   = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic [7:0]  s_tdata   = 8'd0;
    logic [1:0]  s_tuser   = 2'd0;   // [0] req_type, [1] new_conn
    logic        m_tready  = 1'b0;
    wire         s_tready;
    wire         m_tvalid;
    wire  [79:0] m_tdata;
    wire  [2:0]  m_tuser;
    wire         m_tlast;

    handshake_tracker tracker = new();

    bit          send_idle = 1'b1;
    bit          recv_idle = 1'b1;
    int          live_words;
    int          cycle_count;
    logic [7:0]  req_bytes[$];
    logic [7:0]  rep_bytes[$];

    socks_handshake_sniffer i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .o_m_axis_tuser  (m_tuser),
        .o_m_axis_tlast  (m_tlast)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // watchdog
    initial begin
        cycle_count = 0;
        while (cycle_count < LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("CHECKS FAILED");
        $finish;
    end

    // result monitor
    always @(posedge i_clk) begin
        if (i_rst_n && m_tvalid && m_tready) tracker.check_result(m_tdata, m_tuser, m_tlast);
    end

    // result receiver: random stall before each word
    initial begin
        int stall;
        wait (i_rst_n === 1'b1);
        forever begin
            @(negedge i_clk);
            stall = recv_idle ? $urandom_range(0, 12) : 0;
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            m_tready <= 1'b1;
            do @(posedge i_clk); while (!m_tvalid);
        end
    end

    function automatic logic [7:0] rand_byte();
        return 8'($urandom_range(0, 255));
    endfunction

    // name lengths: mostly short, a few at the length limit
    function automatic int name_len(int cap);
        int r, n;
        r = $urandom_range(0, 99);
        if (r < 12) n = 0;
        else if (r < 88) n = $urandom_range(1, 8);
        else if (r < 97) n = $urandom_range(9, 40);
        else n = $urandom_range(254, 256);
        return (n > cap) ? cap : n;
    endfunction

    // one byte word on the input stream; returns right after the accepting edge
    task automatic send_word(logic [7:0] b, bit from_proxy, bit new_conn);
        int gap;
        @(negedge i_clk);
        gap = send_idle ? $urandom_range(0, 12) : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tuser  <= {new_conn, from_proxy};
        do @(posedge i_clk); while (!s_tready);
        if (tracker.note_byte(b, from_proxy, new_conn)) live_words++;
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        s_tvalid <= 1'b0;
        while (tracker.pending() != 0) @(negedge i_clk);
    endtask

    task automatic add_name(int len, bit nonzero);
        for (int i = 0; i < len; i++)
            req_bytes.push_back(nonzero ? 8'($urandom_range(1, 255)) : rand_byte());
    endtask

    // build one connection's request and reply, optionally damage it, then send
    task automatic run_connection(bit long_user);
        int  style, n, len, sel, idx;
        bit  first, take_rep, mixed;
        req_bytes.delete();
        rep_bytes.delete();
        style     = long_user ? 0 : $urandom_range(0, 9);
        send_idle = ($urandom_range(0, 3) != 0);
        recv_idle = ($urandom_range(0, 3) != 0);

        // random garbage with mixed streams and stray new_conn marks
        if (style == 9) begin
            n = $urandom_range(1, 20);
            for (int i = 0; i < n; i++)
                send_word(rand_byte(), 1'($urandom_range(0, 1)),
                          (i == 0) || ($urandom_range(0, 15) == 0));
            return;
        end

        if (style < 5) begin
            // SOCKS4: plain address, zero address, or 4A domain form
            req_bytes = {VER_SOCKS4, CMD_CONNECT, rand_byte(), rand_byte()};
            if (style == 0) begin
                for (int i = 0; i < 4; i++) req_bytes.push_back(rand_byte());
            end else if (style == 1) begin
                for (int i = 0; i < 4; i++) req_bytes.push_back(8'd0);
            end else begin
                req_bytes = {req_bytes, 8'd0, 8'd0, 8'd0, 8'($urandom_range(1, 255))};
            end
            add_name(long_user ? 256 : name_len(256), 1'b1);
            req_bytes.push_back(8'd0);
            if (style >= 2) begin
                add_name(name_len(256), 1'b1);
                req_bytes.push_back(8'd0);
            end
            rep_bytes = {8'd0, S4_GRANTED};
            for (int i = 0; i < 6; i++) rep_bytes.push_back(rand_byte());
        end else begin
            // SOCKS5: method list, then request with IPv4 or domain address
            n = ($urandom_range(0, 15) == 0) ? 255 : $urandom_range(0, 3);
            req_bytes = {VER_SOCKS5, 8'(n)};
            add_name(n, 1'b0);
            req_bytes = {req_bytes, VER_SOCKS5, rand_byte(), rand_byte()};
            if ($urandom_range(0, 1) == 0) begin
                req_bytes.push_back(ATYP_IPV4);
                add_name(4, 1'b0);
            end else begin
                len = name_len(255);
                req_bytes = {req_bytes, ATYP_DOMAIN, 8'(len)};
                add_name(len, 1'b0);
            end
            add_name(2, 1'b0);
            rep_bytes = {VER_SOCKS5, rand_byte(), VER_SOCKS5, S5_SUCCEEDED, rand_byte()};
            if ($urandom_range(0, 1) == 0) begin
                rep_bytes.push_back(ATYP_IPV4);
                for (int i = 0; i < 6; i++) rep_bytes.push_back(rand_byte());
            end else begin
                len = ($urandom_range(0, 23) == 0) ? 255 : $urandom_range(0, 12);
                rep_bytes = {rep_bytes, ATYP_DOMAIN, 8'(len)};
                for (int i = 0; i < len + 2; i++) rep_bytes.push_back(rand_byte());
            end
        end

        // damage about one connection in four
        if (!long_user && $urandom_range(0, 3) == 0) begin
            sel = $urandom_range(0, 4);
            case (sel)
                0: begin
                    idx = $urandom_range(0, req_bytes.size() - 1);
                    req_bytes[idx] = rand_byte();
                end
                1: begin
                    idx = $urandom_range(0, rep_bytes.size() - 1);
                    rep_bytes[idx] = rand_byte();
                end
                2: begin
                    n = $urandom_range(1, req_bytes.size());
                    while (req_bytes.size() > n) void'(req_bytes.pop_back());
                end
                3: begin
                    n = $urandom_range(0, rep_bytes.size() - 1);
                    while (rep_bytes.size() > n) void'(rep_bytes.pop_back());
                end
                default: begin
                    // trailing words after the handshake
                    for (int i = 0; i < 3; i++) begin
                        req_bytes.push_back(rand_byte());
                        rep_bytes.push_back(rand_byte());
                    end
                end
            endcase
        end

        // merge the two streams; the first word opens the connection
        mixed = $urandom_range(0, 1);
        first = 1'b1;
        while (req_bytes.size() != 0 || rep_bytes.size() != 0) begin
            if (rep_bytes.size() == 0) take_rep = 1'b0;
            else if (req_bytes.size() == 0) take_rep = 1'b1;
            else if (first) take_rep = ($urandom_range(0, 9) == 0);
            else take_rep = mixed ? 1'($urandom_range(0, 1)) : 1'b0;
            send_word(take_rep ? rep_bytes.pop_front() : req_bytes.pop_front(), take_rep, first);
            first = 1'b0;
        end
    endtask

    // stimulus
    initial begin
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reply word before any version is known, then an ignored word
        send_word(8'hFF, FROM_PROXY, 1'b1);
        send_word(VER_SOCKS5, FROM_CLIENT, 1'b0);
        // unknown version
        send_word(8'h00, FROM_CLIENT, 1'b1);
        // SOCKS4 with a command other than connect
        send_word(VER_SOCKS4, FROM_CLIENT, 1'b1);
        send_word(8'h02, FROM_CLIENT, 1'b0);
        // SOCKS5 with an empty domain, all-ones unchecked bytes and port
        send_word(VER_SOCKS5, FROM_CLIENT, 1'b1);
        send_word(8'h00, FROM_CLIENT, 1'b0);
        send_word(VER_SOCKS5, FROM_CLIENT, 1'b0);
        send_word(8'hFF, FROM_CLIENT, 1'b0);
        send_word(8'hFF, FROM_CLIENT, 1'b0);
        send_word(ATYP_DOMAIN, FROM_CLIENT, 1'b0);
        send_word(8'h00, FROM_CLIENT, 1'b0);
        send_word(8'hFF, FROM_CLIENT, 1'b0);
        send_word(8'hFF, FROM_CLIENT, 1'b0);
        // SOCKS5 request with a bad version byte
        send_word(VER_SOCKS5, FROM_CLIENT, 1'b1);
        send_word(8'h00, FROM_CLIENT, 1'b0);
        send_word(8'h06, FROM_CLIENT, 1'b0);
        // SOCKS5 request with an unknown address type
        send_word(VER_SOCKS5, FROM_CLIENT, 1'b1);
        send_word(8'h01, FROM_CLIENT, 1'b0);
        send_word(8'h80, FROM_CLIENT, 1'b0);
        send_word(VER_SOCKS5, FROM_CLIENT, 1'b0);
        send_word(CMD_CONNECT, FROM_CLIENT, 1'b0);
        send_word(8'h00, FROM_CLIENT, 1'b0);
        send_word(8'h04, FROM_CLIENT, 1'b0);
        wait_drained();

        // random handshakes; the first one carries an overlong user name
        live_words = 0;
        run_connection(1'b1);
        while (live_words < 550) begin
            run_connection(1'b0);
            if ($urandom_range(0, 5) == 0) wait_drained();
        end

        wait_drained();
        repeat (20) @(negedge i_clk);
        if (tracker.errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
